// ===== rtl/bsfe_pkg.sv =====
// bsfe_pkg: types, widths and constants of the binary sensor fill estimator.
// Used by every module of the block; depends on nothing.
package bsfe_pkg;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int CNT_W  = 16;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = FRAC_W + 1;
  localparam int CONF_W = 32 + FRAC_W;

  localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << FRAC_W;

  localparam int SQ_W   = 2 * FRAC_W + 1;
  localparam int T2_W   = 2 * CNT_W;
  localparam int T3_W   = 3 * CNT_W;
  localparam int HF_W   = CNT_W + FRAC_W;
  localparam int IN_W   = CNT_W + 2 * FRAC_W;
  localparam int PD_W   = CNT_W + SQ_W;
  localparam int DD_W   = 2 * SQ_W;
  localparam int CDEN_W = imax(DD_W, 2 * CNT_W + FRAC_W);
  localparam int MA_W   = imax(T3_W, IN_W);
  localparam int MB_W   = SQ_W;
  localparam int MLO_W  = (MA_W + 1) / 2;
  localparam int MHI_W  = MA_W - MLO_W;
  localparam int CNUM_W = MA_W + MB_W + FRAC_W;
  localparam int ENUM_W = CNT_W + 2 * FRAC_W;
  localparam int EDEN_W = CNT_W + FRAC_W + 1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FLAG   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;

  localparam logic REG_BLACK = 1'b0;
  localparam logic REG_WHITE = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] black_count;
    logic [CNT_W-1:0] total_count;
  } in_t;

  typedef struct packed {
    logic [ACC_W-1:0]  estimate;
    logic [CONF_W-1:0] confidence;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic valid;
    logic no_obs;
    logic clamp_lo;
    logic clamp_hi;
  } bsfe_ctl_t;

endpackage

// ===== rtl/binary_sensor_fill_estimator.sv =====
// Binary sensor fill estimator: fill ratio and confidence from black and total counts.
// Pipeline from an accepted input transaction to its result: 6 front-end stages,
// 1 divider setup stage, 48 divider stages of one quotient bit each, 1 output stage.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Reset (rst, synchronous): pipeline emptied, both accuracies set to 1.0.
// Depends on bsfe_pkg, bsfe_front, bsfe_div.
module binary_sensor_fill_estimator import bsfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [ACC_W-1:0] cfg_data
);

  logic [ACC_W-1:0] black_acc, white_acc;
  logic             en;

  bsfe_ctl_t         ctl;
  logic [CNUM_W-1:0] cnum;
  logic [CDEN_W-1:0] cden;
  logic [ENUM_W-1:0] est_num;
  logic [EDEN_W-1:0] est_den;

  logic              cv, ev, cflag, eflag;
  logic [CONF_W-1:0] cquo, equo;
  logic              no_obs;
  logic [1:0]        clamps;
  logic [ACC_W-1:0]  est_val;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_acc <= ONE_Q;
      white_acc <= ONE_Q;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BLACK: black_acc <= cfg_data;
        REG_WHITE: white_acc <= cfg_data;
        default: ;
      endcase
    end
  end

  bsfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .black_acc (black_acc),
    .white_acc (white_acc),
    .ctl       (ctl),
    .cnum      (cnum),
    .cden      (cden),
    .est_num   (est_num),
    .est_den   (est_den)
  );

  bsfe_div #(
    .NW (CNUM_W),
    .DW (CDEN_W),
    .QW (CONF_W),
    .SW (1)
  ) u_conf_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ctl.valid),
    .num       (cnum),
    .den       (cden),
    .side_in   (ctl.no_obs),
    .out_valid (cv),
    .quo       (cquo),
    .flag      (cflag),
    .side_out  (no_obs)
  );

  bsfe_div #(
    .NW (ENUM_W),
    .DW (EDEN_W),
    .QW (CONF_W),
    .SW (2)
  ) u_est_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ctl.valid),
    .num       (est_num),
    .den       (est_den),
    .side_in   ({ctl.clamp_lo, ctl.clamp_hi}),
    .out_valid (ev),
    .quo       (equo),
    .flag      (eflag),
    .side_out  (clamps)
  );

  always_comb begin
    if (clamps[1]) begin
      est_val = '0;
    end else if (clamps[0] || eflag || (equo > CONF_W'(ONE_Q))) begin
      est_val = ONE_Q;
    end else begin
      est_val = equo[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv && ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (no_obs) begin
        out_data.estimate   <= '0;
        out_data.confidence <= '0;
        out_data.status     <= ST_NODATA;
      end else begin
        out_data.estimate   <= est_val;
        out_data.confidence <= cquo;
        out_data.status     <= cflag ? ST_FLAG : ST_OK;
      end
    end
  end

endmodule

// ===== rtl/bsfe_front.sv =====
// bsfe_front: six-stage front end that forms numerators and denominators
// for the estimate and confidence quotients. Depends on bsfe_pkg.
module bsfe_front import bsfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  in_t               in_data,
  input  logic [ACC_W-1:0]  black_acc,
  input  logic [ACC_W-1:0]  white_acc,
  output bsfe_ctl_t         ctl,
  output logic [CNUM_W-1:0] cnum,
  output logic [CDEN_W-1:0] cden,
  output logic [ENUM_W-1:0] est_num,
  output logic [EDEN_W-1:0] est_den
);

  localparam int PL_W = MLO_W + MB_W;
  localparam int PH_W = MHI_W + MB_W;
  localparam int PR_W = MA_W + MB_W;

  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic [CNT_W-1:0] h1, t1;
  logic [ACC_W-1:0] b1, w1;

  // stage 2
  logic [ACC_W:0]   sum1;
  logic [ACC_W-1:0] omw1, omb1;
  logic [CNT_W-1:0] th1;
  logic             t02, pf2;
  logic [CNT_W-1:0] h2, tt2, th2;
  logic [ACC_W-1:0] dd2, sm2;
  logic [SQ_W-1:0]  wsq2, omwsq2, bsq2, ombsq2;
  logic [T2_W-1:0]  tsq2, hth2;
  logic [HF_W-1:0]  omwt2, bt2, hf2;

  // stage 3
  logic             t03, pf3, lo3, hi3;
  logic [SQ_W-1:0]  d2_3;
  logic [T3_W-1:0]  tcb3;
  logic [PD_W-1:0]  ial3, ibl3, iah3, ibh3;
  logic [DD_W-1:0]  dl3, dh3;
  logic [HF_W-1:0]  en3, hf3;
  logic [EDEN_W-1:0] ed3;
  logic [T2_W-1:0]  hth3;
  logic [CNT_W-1:0] tt3;

  // stage 4
  logic             clo3, chi3, ci3;
  logic             t04, pf4, clo4, chi4, ci4;
  logic [IN_W-1:0]  inner4;
  logic [CDEN_W-1:0] cden4;
  logic [ENUM_W-1:0] enm4;
  logic [EDEN_W-1:0] eden4;
  logic [T3_W-1:0]  tcb4;
  logic [SQ_W-1:0]  d2_4;

  // stage 5
  logic [MA_W-1:0]  ma4;
  logic [MB_W-1:0]  mb4;
  logic             t05, clo5, chi5, sh5;
  logic [PL_W-1:0]  pl5;
  logic [PH_W-1:0]  ph5;
  logic [CDEN_W-1:0] cden5;
  logic [ENUM_W-1:0] enm5;
  logic [EDEN_W-1:0] eden5;

  // stage 6
  logic [PR_W-1:0]  prod5;
  logic             t06, clo6, chi6;
  logic [CNUM_W-1:0] cnum6;
  logic [CDEN_W-1:0] cden6;
  logic [ENUM_W-1:0] enm6;
  logic [EDEN_W-1:0] eden6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_comb begin
    sum1 = {1'b0, b1} + {1'b0, w1};
    omw1 = ONE_Q - w1;
    omb1 = ONE_Q - b1;
    th1  = t1 - h1;
    clo3 = !pf3 && lo3;
    chi3 = !pf3 && !lo3 && hi3;
    ci3  = !pf3 && !lo3 && !hi3;
    ma4  = (pf4 || ci4) ? MA_W'(tcb4) : MA_W'(inner4);
    mb4  = pf4 ? MB_W'(1) : d2_4;
    prod5 = (PR_W'(ph5) << MLO_W) + PR_W'(pl5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: clamp inputs
      t1 <= in_data.total_count;
      h1 <= (in_data.black_count > in_data.total_count) ?
            in_data.total_count : in_data.black_count;
      b1 <= (black_acc > ONE_Q) ? ONE_Q : black_acc;
      w1 <= (white_acc > ONE_Q) ? ONE_Q : white_acc;

      // stage 2: squares and scaled counts
      t02    <= (t1 == '0);
      pf2    <= (b1 == ONE_Q) && (w1 == ONE_Q);
      h2     <= h1;
      tt2    <= t1;
      th2    <= th1;
      dd2    <= (sum1 >= {1'b0, ONE_Q}) ? ACC_W'(sum1 - {1'b0, ONE_Q}) :
                ACC_W'({1'b0, ONE_Q} - sum1);
      sm2    <= ACC_W'(sum1 - {1'b0, ONE_Q});
      wsq2   <= SQ_W'(w1) * SQ_W'(w1);
      omwsq2 <= SQ_W'(omw1) * SQ_W'(omw1);
      bsq2   <= SQ_W'(b1) * SQ_W'(b1);
      ombsq2 <= SQ_W'(omb1) * SQ_W'(omb1);
      tsq2   <= T2_W'(t1) * T2_W'(t1);
      hth2   <= T2_W'(h1) * T2_W'(th1);
      omwt2  <= HF_W'(omw1) * HF_W'(t1);
      bt2    <= HF_W'(b1) * HF_W'(t1);
      hf2    <= {h1, FRAC_W'(0)};

      // stage 3: clamp tests and partial terms
      t03  <= t02;
      pf3  <= pf2;
      lo3  <= (hf2 <= omwt2);
      hi3  <= (hf2 >= bt2);
      d2_3 <= SQ_W'(dd2) * SQ_W'(dd2);
      tcb3 <= T3_W'(tsq2) * T3_W'(tt2);
      ial3 <= PD_W'(h2) * PD_W'(wsq2);
      ibl3 <= PD_W'(th2) * PD_W'(omwsq2);
      iah3 <= PD_W'(th2) * PD_W'(bsq2);
      ibh3 <= PD_W'(h2) * PD_W'(ombsq2);
      dl3  <= DD_W'(wsq2) * DD_W'(omwsq2);
      dh3  <= DD_W'(bsq2) * DD_W'(ombsq2);
      en3  <= hf2 - omwt2;
      ed3  <= EDEN_W'(tt2) * EDEN_W'(sm2);
      hth3 <= hth2;
      hf3  <= hf2;
      tt3  <= tt2;

      // stage 4: case select
      t04    <= t03;
      pf4    <= pf3;
      clo4   <= clo3;
      chi4   <= chi3;
      ci4    <= ci3;
      inner4 <= clo3 ? IN_W'(ial3 + ibl3) : IN_W'(iah3 + ibh3);
      if (pf3) begin
        cden4 <= CDEN_W'(hth3);
      end else if (clo3) begin
        cden4 <= CDEN_W'(dl3);
      end else if (chi3) begin
        cden4 <= CDEN_W'(dh3);
      end else begin
        cden4 <= CDEN_W'({hth3, FRAC_W'(0)});
      end
      enm4  <= pf3 ? ENUM_W'(hf3) : ENUM_W'({en3, FRAC_W'(0)});
      eden4 <= pf3 ? EDEN_W'(tt3) : ed3;
      tcb4  <= tcb3;
      d2_4  <= d2_3;

      // stage 5: split multiply
      t05   <= t04;
      clo5  <= clo4;
      chi5  <= chi4;
      sh5   <= !ci4;
      pl5   <= PL_W'(ma4[MLO_W-1:0]) * PL_W'(mb4);
      ph5   <= PH_W'(ma4[MA_W-1:MLO_W]) * PH_W'(mb4);
      cden5 <= cden4;
      enm5  <= enm4;
      eden5 <= eden4;

      // stage 6: combine partial products
      t06   <= t05;
      clo6  <= clo5;
      chi6  <= chi5;
      cnum6 <= sh5 ? CNUM_W'({prod5, FRAC_W'(0)}) : CNUM_W'(prod5);
      cden6 <= cden5;
      enm6  <= enm5;
      eden6 <= eden5;
    end
  end

  assign ctl.valid    = v6;
  assign ctl.no_obs   = t06;
  assign ctl.clamp_lo = clo6;
  assign ctl.clamp_hi = chi6;
  assign cnum    = cnum6;
  assign cden    = cden6;
  assign est_num = enm6;
  assign est_den = eden6;

endmodule

// ===== rtl/bsfe_div.sv =====
// bsfe_div: pipelined restoring divider, one quotient bit per stage,
// saturating on a zero divisor or a quotient wider than QW bits. Depends on bsfe_pkg.
module bsfe_div import bsfe_pkg::*; #(
  parameter int NW = CNUM_W,
  parameter int DW = CDEN_W,
  parameter int QW = CONF_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          flag,
  output logic [SW-1:0] side_out
);

  localparam int NX = imax(NW, QW + 1);
  localparam int CW = imax(NX - QW, DW);

  logic [NX-1:0]    numx;
  logic [NX-QW-1:0] nhi;
  logic             sat;

  logic [DW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] low_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          flag_r [QW+1];
  logic          vld_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_comb begin
    numx = NX'(num);
    nhi  = numx[NX-1:QW];
    sat  = (den == '0) || (CW'(nhi) >= CW'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(nhi);
      den_r[0]  <= den;
      low_r[0]  <= numx[QW-1:0];
      q_r[0]    <= '0;
      flag_r[0] <= sat;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] rs;
    logic        ge;

    assign rs = {rem_r[k-1], low_r[k-1][QW-1]};
    assign ge = (rs >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(rs - {1'b0, den_r[k-1]}) : DW'(rs);
        den_r[k]  <= den_r[k-1];
        low_r[k]  <= low_r[k-1] << 1;
        q_r[k]    <= (q_r[k-1] << 1) | QW'(ge);
        flag_r[k] <= flag_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign quo       = flag_r[QW] ? '1 : q_r[QW];
  assign flag      = flag_r[QW];
  assign side_out  = side_r[QW];

endmodule

// ===== rtl/bsfe_checker.sv =====
// bsfe_checker: port-level checks of the fill estimator, bound to the top level.
// Depends on bsfe_pkg and binary_sensor_fill_estimator.
module bsfe_checker import bsfe_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NODATA) |->
      (out_data.estimate == '0) && (out_data.confidence == '0))
    else $error("empty count result not zero");

  a_est_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.estimate <= ONE_Q)
    else $error("estimate above 1.0");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind binary_sensor_fill_estimator bsfe_checker u_bsfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
